[hdl/rvr_pkg.sv]
// ----------------------------------------------------------------------------
// rvr_pkg
// Shared constants and types for the group reversal block.
// ----------------------------------------------------------------------------
`default_nettype none

package rvr_pkg;

  localparam int DATA_W        = 64;
  localparam int CFG_W         = 5;
  localparam int MAX_GROUP_DEF = 16;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } rvr_state_t;

  // tags carried with each read of the group buffer
  typedef struct packed {
    logic group_end;
    logic stream_end;
  } rvr_tag_t;

endpackage

`default_nettype wire

[hdl/rvr_ram.sv]
// ----------------------------------------------------------------------------
// rvr_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rvr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/reverse_in_groups.sv]
// ----------------------------------------------------------------------------
// reverse_in_groups
// Collects stream items into a group buffer and sends each group out reversed.
// ----------------------------------------------------------------------------
// Fill: one item accepted per cycle, written into the group buffer RAM.
// Drain: input is held off; the first result passes the RAM read and the
//   output register after the closing item, then one result per cycle while
//   m_axis_tready is high (one RAM read per cycle, a skid register covers
//   the read latency).
// Reset: fill count cleared, group size 1; buffer contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module reverse_in_groups #(
  parameter int MAX_GROUP = rvr_pkg::MAX_GROUP_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // config
  input  wire logic                             cfg_wr_en,
  input  wire logic [rvr_pkg::CFG_W-1:0]        cfg_wr_data,   // group_size
  // input stream
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic signed [rvr_pkg::DATA_W-1:0] s_axis_tdata, // element
  input  wire logic                             s_axis_tlast,  // stream_last
  // output stream
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic signed [rvr_pkg::DATA_W-1:0] m_axis_tdata, // element_out
  output      logic                             m_axis_tlast,  // group_end
  output      logic [0:0]                       m_axis_tuser   // stream_end
);

  import rvr_pkg::*;

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);

  rvr_state_t state;
  logic [CW-1:0] group_size;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] rd_left;
  logic          last_q;

  logic                     rd_pending;
  rvr_tag_t                 pend_tag;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;
  rvr_tag_t                 out_tag;
  logic                     skid_valid;
  logic signed [DATA_W-1:0] skid_data;
  rvr_tag_t                 skid_tag;

  logic              accept;
  logic              wr_en;
  logic              close;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              pop;
  logic              out_free;
  logic [1:0]        occ;
  logic [CFG_W-1:0]  cfg_clamped;

  // clamp written group size into 1..MAX_GROUP
  always_comb begin
    cfg_clamped = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      cfg_clamped = CFG_W'(1);
    end else if (int'(cfg_wr_data) > MAX_GROUP) begin
      cfg_clamped = CFG_W'(MAX_GROUP);
    end
  end

  assign s_axis_tready = (state == ST_FILL);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = accept && (int'(fill) < MAX_GROUP);
  assign fill_next     = wr_en ? fill + CW'(1) : fill;
  assign close         = s_axis_tlast || (fill_next >= group_size);

  assign pop      = out_valid && m_axis_tready;
  assign out_free = !out_valid || pop;
  assign occ      = 2'(out_valid) + 2'(skid_valid) + 2'(rd_pending) - 2'(pop);
  assign rd_en    = (state == ST_DRAIN) && (rd_left != '0) && (occ < 2'd2);
  assign rd_addr  = AW'(rd_left - CW'(1));

  rvr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_GROUP)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[AW-1:0]),
    .wr_data (s_axis_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      group_size <= CW'(1);
      fill       <= '0;
      rd_left    <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        group_size <= CW'(cfg_clamped);
      end

      case (state)
        ST_FILL: begin
          if (accept) begin
            if (close) begin
              fill    <= '0;
              rd_left <= fill_next;
              last_q  <= s_axis_tlast;
              state   <= ST_DRAIN;
            end else begin
              fill <= fill_next;
            end
          end
        end
        ST_DRAIN: begin
          if (rd_en) begin
            rd_left <= rd_left - CW'(1);
          end
          if ((rd_left == '0) && !rd_pending && !out_valid && !skid_valid) begin
            state <= ST_FILL;
          end
        end
        default: state <= ST_FILL;
      endcase

      // read pipeline: tag travels with the RAM read
      rd_pending           <= rd_en;
      pend_tag.group_end   <= (rd_left == CW'(1));
      pend_tag.stream_end  <= (rd_left == CW'(1)) && last_q;

      // output register with skid
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          out_tag    <= skid_tag;
          skid_valid <= rd_pending;
          skid_data  <= rd_data;
          skid_tag   <= pend_tag;
        end else if (rd_pending) begin
          out_valid <= 1'b1;
          out_data  <= rd_data;
          out_tag   <= pend_tag;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (rd_pending) begin
        skid_valid <= 1'b1;
        skid_data  <= rd_data;
        skid_tag   <= pend_tag;
      end
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tlast    = out_tag.group_end;
  assign m_axis_tuser[0] = out_tag.stream_end;

endmodule

`default_nettype wire
